// ===== src/umd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// umd_pkg: shared types for the unsigned multiply-divide pipeline
// Word layouts for the operand, result and divider chain stages.
// ----------------------------------------------------------------------------
package umd_pkg;

	localparam int unsigned WORD_W = 64;
	localparam int unsigned HALF_W = WORD_W / 2;
	localparam int unsigned PROD_W = 2 * WORD_W;
	// one restoring step per product bit
	localparam int unsigned DIV_STEPS = PROD_W;

	typedef struct packed {
		logic [WORD_W-1:0] value;
		logic [WORD_W-1:0] scale_mul;
		logic [WORD_W-1:0] scale_div;
	} in_word_t;

	typedef struct packed {
		logic [WORD_W-1:0] quotient;
		logic              div_zero;
		logic              overflow;
	} out_word_t;

	// word handed from one divider cell to the next
	typedef struct packed {
		logic              vld;
		logic [WORD_W-1:0] d;
		logic [WORD_W-1:0] rem;
		// dividend bits still to enter at the top, quotient bits at the bottom
		logic [PROD_W-1:0] dq;
	} div_word_t;

endpackage : umd_pkg
`default_nettype wire

// ===== src/umd_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// umd_mul: pipelined 64x64 -> 128 multiplier
// Four 32x32 partial products, then two wide additions over two stages.
// Emits the first divider chain word with a cleared remainder.
// ----------------------------------------------------------------------------
module umd_mul (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_vld,
	input  wire umd_pkg::in_word_t  op,
	output umd_pkg::div_word_t      dw
);
	import umd_pkg::*;

	logic                vld_s1, vld_s2, vld_s3;
	logic [WORD_W-1:0]   p00_s1, p01_s1, p10_s1, p11_s1, d_s1;
	logic [PROD_W-1:0]   t_s2;
	logic [WORD_W-1:0]   p10_s2, d_s2;
	logic [PROD_W-1:0]   prod_s3;
	logic [WORD_W-1:0]   d_s3;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// stage 1: partial products
	always_ff @(posedge clk) begin
		p00_s1 <= WORD_W'(op.value[HALF_W-1:0])      * WORD_W'(op.scale_mul[HALF_W-1:0]);
		p01_s1 <= WORD_W'(op.value[HALF_W-1:0])      * WORD_W'(op.scale_mul[WORD_W-1:HALF_W]);
		p10_s1 <= WORD_W'(op.value[WORD_W-1:HALF_W]) * WORD_W'(op.scale_mul[HALF_W-1:0]);
		p11_s1 <= WORD_W'(op.value[WORD_W-1:HALF_W]) * WORD_W'(op.scale_mul[WORD_W-1:HALF_W]);
		d_s1   <= op.scale_div;
	end

	// stage 2: outer products plus first cross term
	always_ff @(posedge clk) begin
		t_s2   <= {p11_s1, p00_s1}
		        + {{HALF_W{1'b0}}, p01_s1, {HALF_W{1'b0}}};
		p10_s2 <= p10_s1;
		d_s2   <= d_s1;
	end

	// stage 3: second cross term
	always_ff @(posedge clk) begin
		prod_s3 <= t_s2 + {{HALF_W{1'b0}}, p10_s2, {HALF_W{1'b0}}};
		d_s3    <= d_s2;
	end

	assign dw.vld = vld_s3;
	assign dw.d   = d_s3;
	assign dw.rem = '0;
	assign dw.dq  = prod_s3;

`ifndef SYNTHESIS
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		dw.vld |-> $past(in_vld, 3))
		else $error("umd_mul: product valid without an input three cycles back");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_vld |-> ##3 dw.vld)
		else $error("umd_mul: input word lost in multiplier");
	a_rem0: assert property (@(posedge clk) disable iff (!arst_n)
		dw.vld |-> dw.rem == '0)
		else $error("umd_mul: chain must start from a zero remainder");
`endif

endmodule : umd_mul
`default_nettype wire

// ===== src/umd_div_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// umd_div_cell: one restoring division step
// Shifts the next dividend bit into the remainder, subtracts the divisor
// when it fits and shifts the quotient bit in at the bottom.
// ----------------------------------------------------------------------------
module umd_div_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire umd_pkg::div_word_t din,
	output umd_pkg::div_word_t      dout
);
	import umd_pkg::*;

	logic [WORD_W:0]   r2;
	logic [WORD_W:0]   diff;
	logic              ge;
	logic              vld_q;
	logic [WORD_W-1:0] d_q, rem_q;
	logic [PROD_W-1:0] dq_q;

	// trial subtract on the widened remainder
	always_comb begin
		r2   = {din.rem, din.dq[PROD_W-1]};
		diff = r2 - {1'b0, din.d};
		ge   = !diff[WORD_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= din.vld;
		end
	end

	always_ff @(posedge clk) begin
		d_q   <= din.d;
		rem_q <= ge ? diff[WORD_W-1:0] : r2[WORD_W-1:0];
		dq_q  <= {din.dq[PROD_W-2:0], ge};
	end

	assign dout.vld = vld_q;
	assign dout.d   = d_q;
	assign dout.rem = rem_q;
	assign dout.dq  = dq_q;

`ifndef SYNTHESIS
	a_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(din.vld && din.d != '0 && din.rem < din.d) |=> (dout.rem < dout.d))
		else $error("umd_div_cell: remainder not below divisor");
	a_vld: assert property (@(posedge clk) disable iff (!arst_n)
		dout.vld |-> $past(din.vld))
		else $error("umd_div_cell: valid without input word");
	a_d: assert property (@(posedge clk) disable iff (!arst_n)
		din.vld |=> dout.d == $past(din.d))
		else $error("umd_div_cell: divisor not carried");
`endif

endmodule : umd_div_cell
`default_nettype wire

// ===== src/unsigned_mul_div_64_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// unsigned_mul_div_64_top: pipelined (value * scale_mul) / scale_div
// Full 128-bit product, then 128 restoring division cells in a row.
// ----------------------------------------------------------------------------
// Usage:
//   Drive op with value, scale_mul and scale_div and raise start for one
//   cycle per word. busy is always low, so a word is taken on every edge
//   that sees start high: one word per cycle, back to back.
//   Each result appears on res for exactly one cycle with done high,
//   after 3 multiplier stages, 128 division cells (one per product bit)
//   and one output register. Results leave in the order the words came in.
//   The receiver cannot stall, so it must take res whenever done is high.
//   quotient is the low 64 bits of the truncated quotient; overflow marks
//   a quotient of 2^64 or more. A zero divisor gives an all-ones quotient
//   with div_zero set and overflow clear.
//   Reset clears all valid bits at once; words in flight are dropped and
//   no done pulse follows until new words are taken.
// ----------------------------------------------------------------------------
module unsigned_mul_div_64_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output wire logic               busy,
	input  wire umd_pkg::in_word_t  op,
	output wire logic               done,
	output umd_pkg::out_word_t      res
);
	import umd_pkg::*;

	div_word_t chain [DIV_STEPS+1];
	logic      acc;
	logic      done_q;
	out_word_t res_q;
	logic      dz;
	logic      ovf;

	assign busy = 1'b0;
	assign acc  = start && !busy;

	// multiplier front end
	umd_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (acc),
		.op     (op),
		.dw     (chain[0])
	);

	// row of division cells
	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
		umd_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.din    (chain[i]),
			.dout   (chain[i+1])
		);
	end

	// result flags from the finished quotient
	always_comb begin
		dz  = (chain[DIV_STEPS].d == '0);
		ovf = |chain[DIV_STEPS].dq[PROD_W-1:WORD_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= chain[DIV_STEPS].vld;
		end
	end

	always_ff @(posedge clk) begin
		res_q.quotient <= dz ? '1 : chain[DIV_STEPS].dq[WORD_W-1:0];
		res_q.div_zero <= dz;
		res_q.overflow <= ovf && !dz;
	end

	assign done = done_q;
	assign res  = res_q;

`ifndef SYNTHESIS
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, DIV_STEPS + 4))
		else $error("top: result without matching word");
	a_nolose: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(DIV_STEPS + 4) done)
		else $error("top: word lost in pipeline");
	a_dz: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.div_zero) |-> (res.quotient == '1 && !res.overflow))
		else $error("top: zero divisor result malformed");
`endif

endmodule : unsigned_mul_div_64_top
`default_nettype wire
